FILE: rtl/core/sawa_pkg.sv
`default_nettype none
package sawa_pkg;

   // frame layout
   localparam int FRAME_BYTES_DEF = 64;
   localparam int HDR_BYTES       = 6;
   localparam int FLAG_IDX        = 4;
   localparam int SEQ_IDX         = 5;
   localparam int PL_ADDR_W       = 10;   // enough for the largest payload area
   localparam int CMDQ_DEPTH_DEF  = 4;

   // crc-32, reflected form
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // control registers
   localparam int          CSR_IDX_W     = 1;
   localparam int          CSR_DATA_W    = 32;
   localparam logic        CSR_TIMEOUT   = 1'b0;
   localparam logic        CSR_ACK       = 1'b1;
   localparam logic [31:0] TIMEOUT_RESET = 32'd10000;
   localparam logic [7:0]  ACK_RESET     = 8'h7F;

   // input operations
   localparam logic [1:0] OP_PAYLOAD = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_ACK     = 2'd2;
   localparam logic [1:0] OP_END     = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last;
      logic       is_retransmit;
      logic       is_end_frame;
      logic       rejected;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_FILLING,
      PH_WAITING,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_WRITE_FRAME,
      CMD_FRAME,
      CMD_REJECT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [PL_ADDR_W-1:0] addr;
      logic [7:0]           data;
      logic                 retx;
      logic                 seal;
      logic                 flag;
      logic                 seq;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CRC_RD,
      BK_CRC_ACC,
      BK_EMIT_RD,
      BK_EMIT_OUT
   } back_state_type;

   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sawa_cmdq.sv
`default_nettype none
module sawa_cmdq import sawa_pkg::*; #(
   parameter int DEPTH = CMDQ_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_item,
   output logic         full,
   output logic         valid,
   input  wire logic    pop,
   output cmd_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/sawa_front.sv
`default_nettype none
module sawa_front import sawa_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire req_type               req_item,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  cmdq_full,
   output logic                       cmd_push,
   output cmd_type                    cmd
);

   localparam int PL_DEPTH = FRAME_BYTES - HDR_BYTES;
   localparam int FILL_W   = $clog2(PL_DEPTH + 1);

   phase_type         phase_ff, phase_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              seq_ff, seq_in;
   logic [31:0]       timer_ff, timer_in;
   logic              end_pending_ff, end_pending_in;
   logic [31:0]       timeout_ff;
   logic [7:0]        ack_ff;

   logic              accept;
   logic [FILL_W-1:0] fill_next;
   logic              frame_full;
   logic [32:0]       timer_inc;
   logic              expired;
   logic              ack_match;

   assign full       = cmdq_full;
   assign accept     = push & ~cmdq_full;
   assign fill_next  = fill_ff + 1'b1;
   assign frame_full = (fill_next == FILL_W'(PL_DEPTH));
   assign timer_inc  = {1'b0, timer_ff} + 33'd1;
   assign expired    = (timer_inc >= {1'b0, timeout_ff});
   assign ack_match  = (req_item.data == ack_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (req_item.op)
            OP_PAYLOAD: begin
               if (phase_ff == PH_FILLING && frame_full) begin
                  phase_in = PH_WAITING;
               end
            end
            OP_ACK: begin
               if (phase_ff == PH_WAITING && ack_match) begin
                  phase_in = end_pending_ff ? PH_DONE : PH_FILLING;
               end
            end
            OP_END: begin
               if (phase_ff == PH_FILLING) begin
                  phase_in = PH_WAITING;
               end
            end
            default: ;
         endcase
      end
   end

   // commands to the back end and counters
   always_comb begin
      cmd_push       = 1'b0;
      cmd            = '0;
      cmd.kind       = CMD_REJECT;
      fill_in        = fill_ff;
      seq_in         = seq_ff;
      timer_in       = timer_ff;
      end_pending_in = end_pending_ff;
      if (accept) begin
         case (req_item.op)
            OP_PAYLOAD: begin
               cmd_push = 1'b1;
               if (phase_ff == PH_FILLING) begin
                  cmd.addr = PL_ADDR_W'(fill_ff);
                  cmd.data = req_item.data;
                  if (frame_full) begin
                     cmd.kind = CMD_WRITE_FRAME;
                     cmd.seal = 1'b1;
                     cmd.flag = 1'b1;
                     cmd.seq  = seq_ff;
                     seq_in   = ~seq_ff;
                     fill_in  = '0;
                     timer_in = '0;
                  end else begin
                     cmd.kind = CMD_WRITE;
                     fill_in  = fill_next;
                  end
               end
            end
            OP_TICK: begin
               if (phase_ff == PH_WAITING) begin
                  if (expired) begin
                     cmd_push = 1'b1;
                     cmd.kind = CMD_FRAME;
                     cmd.retx = 1'b1;
                     timer_in = '0;
                  end else begin
                     timer_in = timer_inc[31:0];
                  end
               end
            end
            OP_ACK: begin
               if (phase_ff != PH_WAITING) begin
                  cmd_push = 1'b1;
               end else begin
                  timer_in = '0;
                  if (!ack_match) begin
                     cmd_push = 1'b1;
                     cmd.kind = CMD_FRAME;
                     cmd.retx = 1'b1;
                  end else if (end_pending_ff) begin
                     // end frame keeps the last sequence byte
                     cmd_push       = 1'b1;
                     cmd.kind       = CMD_FRAME;
                     cmd.seal       = 1'b1;
                     cmd.flag       = 1'b0;
                     cmd.seq        = ~seq_ff;
                     end_pending_in = 1'b0;
                  end
               end
            end
            OP_END: begin
               cmd_push = 1'b1;
               if (phase_ff == PH_FILLING) begin
                  cmd.kind       = CMD_FRAME;
                  cmd.seal       = 1'b1;
                  cmd.flag       = 1'b1;
                  cmd.seq        = seq_ff;
                  seq_in         = ~seq_ff;
                  fill_in        = '0;
                  timer_in       = '0;
                  end_pending_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_FILLING;
         fill_ff        <= '0;
         seq_ff         <= 1'b0;
         timer_ff       <= '0;
         end_pending_ff <= 1'b0;
         timeout_ff     <= TIMEOUT_RESET;
         ack_ff         <= ACK_RESET;
      end else begin
         phase_ff       <= phase_in;
         fill_ff        <= fill_in;
         seq_ff         <= seq_in;
         timer_ff       <= timer_in;
         end_pending_ff <= end_pending_in;
         if (csr_we) begin
            case (csr_index)
               CSR_TIMEOUT: timeout_ff <= csr_wdata;
               CSR_ACK:     ack_ff     <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/sawa_back.sv
`default_nettype none
module sawa_back import sawa_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_item
);

   localparam int PL_DEPTH = FRAME_BYTES - HDR_BYTES;
   localparam int PAW      = $clog2(PL_DEPTH);
   localparam int HWM_W    = $clog2(PL_DEPTH + 1);
   localparam int IDX_W    = $clog2(FRAME_BYTES);

   back_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff;
   logic              flag_ff, seq_ff, retx_ff;
   logic [31:0]       crc_ff, crc_acc_ff;
   logic [HWM_W-1:0]  hwm_ff;
   logic [7:0]        mem [PL_DEPTH];
   logic [7:0]        rd_data_ff;
   logic              rd_known_ff;
   logic              out_valid_ff;
   rsp_type           out_item_ff;

   logic              out_free;
   logic              idx_last;
   logic [IDX_W-1:0]  pl_idx;
   logic [PAW-1:0]    rd_addr;
   logic [PAW-1:0]    wr_addr;
   logic [HWM_W-1:0]  wr_addr_ext;
   logic [7:0]        cur_byte;
   logic [31:0]       crc_next;
   logic [31:0]       crc_shift;
   logic              is_write, is_frame, start_frame;
   logic              mem_we, out_load;
   rsp_type           out_item;

   assign empty       = ~out_valid_ff;
   assign rsp_item    = out_item_ff;
   assign out_free    = ~out_valid_ff | pop;
   assign idx_last    = (idx_ff == IDX_W'(FRAME_BYTES - 1));
   assign pl_idx      = idx_ff - IDX_W'(HDR_BYTES);
   assign rd_addr     = PAW'(pl_idx);
   assign wr_addr     = cmd.addr[PAW-1:0];
   assign wr_addr_ext = HWM_W'(wr_addr);
   assign is_write    = (cmd.kind == CMD_WRITE) || (cmd.kind == CMD_WRITE_FRAME);
   assign is_frame    = (cmd.kind == CMD_WRITE_FRAME) || (cmd.kind == CMD_FRAME);
   assign start_frame = (state_ff == BK_IDLE) && cmd_valid && is_frame;
   assign crc_shift   = crc_ff >> {~idx_ff[1:0], 3'b000};
   assign crc_next    = crc32_byte(crc_acc_ff, cur_byte);

   // byte at the current frame position
   always_comb begin
      if (idx_ff < IDX_W'(FLAG_IDX)) begin
         cur_byte = crc_shift[7:0];
      end else if (idx_ff == IDX_W'(FLAG_IDX)) begin
         cur_byte = {7'd0, flag_ff};
      end else if (idx_ff == IDX_W'(SEQ_IDX)) begin
         cur_byte = {7'd0, seq_ff};
      end else begin
         cur_byte = rd_known_ff ? rd_data_ff : 8'd0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && is_frame) begin
               state_in = cmd.seal ? BK_CRC_RD : BK_EMIT_RD;
            end
         end
         BK_CRC_RD:  state_in = BK_CRC_ACC;
         BK_CRC_ACC: state_in = idx_last ? BK_EMIT_RD : BK_CRC_RD;
         BK_EMIT_RD: state_in = BK_EMIT_OUT;
         BK_EMIT_OUT: begin
            if (out_free) begin
               state_in = idx_last ? BK_IDLE : BK_EMIT_RD;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop  = 1'b0;
      mem_we   = 1'b0;
      out_load = 1'b0;
      out_item = '0;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == CMD_REJECT) begin
                  out_item.last     = 1'b1;
                  out_item.rejected = 1'b1;
                  out_load          = out_free;
                  cmd_pop           = out_free;
               end else begin
                  mem_we  = is_write;
                  cmd_pop = 1'b1;
               end
            end
         end
         BK_EMIT_OUT: begin
            out_item.frame_byte    = cur_byte;
            out_item.last          = idx_last;
            out_item.is_retransmit = retx_ff;
            out_item.is_end_frame  = ~flag_ff;
            out_load               = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         flag_ff      <= 1'b0;
         seq_ff       <= 1'b0;
         crc_ff       <= '0;
         hwm_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start_frame && cmd.seal) begin
            flag_ff <= cmd.flag;
            seq_ff  <= cmd.seq;
         end
         if (state_ff == BK_CRC_ACC && idx_last) begin
            crc_ff <= ~crc_next;
         end
         if (mem_we && wr_addr_ext >= hwm_ff) begin
            hwm_ff <= wr_addr_ext + 1'b1;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // position counter and crc accumulator
   always_ff @(posedge clock) begin
      if (start_frame) begin
         idx_ff     <= cmd.seal ? IDX_W'(FLAG_IDX) : '0;
         retx_ff    <= cmd.retx;
         crc_acc_ff <= CRC_INIT;
      end else if (state_ff == BK_CRC_ACC) begin
         crc_acc_ff <= crc_next;
         idx_ff     <= idx_last ? '0 : idx_ff + 1'b1;
      end else if (state_ff == BK_EMIT_OUT && out_free) begin
         idx_ff <= idx_last ? '0 : idx_ff + 1'b1;
      end
      if (out_load) begin
         out_item_ff <= out_item;
      end
   end

   // payload store, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= cmd.data;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_known_ff <= (HWM_W'(rd_addr) < hwm_ff);
   end

endmodule
`default_nettype wire

FILE: rtl/core/stop_and_wait_arq_sender.sv
`default_nettype none
// stop-and-wait arq sender with crc-32 framing. payload bytes (op 0) fill a frame
// of FRAME_BYTES bytes: 4-byte big-endian crc-32 over the rest, a flag byte (1 data,
// 0 end), an alternating sequence byte and the payload. a full payload or end of
// data (op 3) sends the frame, FRAME_BYTES result transfers with last on the final
// byte, and the sender waits: ticks (op 1) count toward timeout_ticks and resend,
// an ack byte (op 2) equal to ack_value releases the next frame, any other ack
// resends at once. after the last data frame is acknowledged an end frame follows
// and the sender is done. an input that does not fit the current phase gives a
// single result with rejected and last set; such a tick is ignored. the front
// end takes one input per cycle, while the queue is not full, into a 4-deep
// command queue; the back end stores each payload byte as it takes the command,
// and walks the frame through its payload memory: a fresh frame gets a crc pass
// from the flag byte on, then the output pass, a resend only the latter. the
// input reports full only while the command queue is full. control registers are
// written through csr_we / csr_index / csr_wdata: index 0 timeout_ticks, index 1
// ack_value, and should only change while the sender is quiet.
module stop_and_wait_arq_sender import sawa_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF,
   parameter int CMDQ_DEPTH  = CMDQ_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input transfers
   input  wire logic                  push,
   output logic                       full,
   input  wire req_type               req_item,
   // result transfers
   output logic                       empty,
   input  wire logic                  pop,
   output rsp_type                    rsp_item,
   // control registers
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type fe_cmd;
   logic    fe_cmd_push;
   logic    q_full;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_head;

   // phase tracking, counters and control registers
   sawa_front #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmdq_full (q_full),
      .cmd_push  (fe_cmd_push),
      .cmd       (fe_cmd)
   );

   // decouples input acceptance from frame output
   sawa_cmdq #(
      .DEPTH(CMDQ_DEPTH)
   ) u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_cmd_push),
      .push_item (fe_cmd),
      .full      (q_full),
      .valid     (q_valid),
      .pop       (q_pop),
      .head      (q_head)
   );

   // payload store, crc sealing and byte output
   sawa_back #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (q_head),
      .cmd_pop   (q_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire
